### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define SPH_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, reset masks the check
`define SPH_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### src/sph_pkg.sv
// package: types and constants of the spill profile histogrammer
`default_nettype none

package sph_pkg;

	localparam int TS_W     = 30;
	localparam int TICK_W   = 48;
	localparam int CNT_W    = 32;
	localparam int BIDX_W   = 6;
	localparam int MODE_W   = 2;
	localparam int WORD_W   = 32;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 30;
	localparam int OUT_FIELDS_W = BIDX_W + CNT_W + CNT_W + TICK_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// stream kinds carried on s_tuser
	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SPILL  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_ENABLE = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_TPS    = 1'b1;

	localparam logic [CFG_DATA_W-1:0] TPS_RESET  = 30'd100000000;
	localparam logic [TICK_W-1:0]     TICK_RESET = 48'd1000000000;
	localparam logic [WORD_W-1:0]     SKIP_BIT   = 32'h8000_0000;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_ADD  = 11'b000_0000_0010,
		ST_MUL0 = 11'b000_0000_0100,
		ST_MUL1 = 11'b000_0000_1000,
		ST_CMP  = 11'b000_0001_0000,
		ST_DIV  = 11'b000_0010_0000,
		ST_RD   = 11'b000_0100_0000,
		ST_WR   = 11'b000_1000_0000,
		ST_TEN  = 11'b001_0000_0000,
		ST_WID  = 11'b010_0000_0000,
		ST_DRAW = 11'b100_0000_0000
	} state_t;

endpackage

`default_nettype wire

### src/spill_profile_histogrammer.sv
// top level: spill time profile built in a bin memory, with readout stream
`default_nettype none

// spill profile histogrammer: one input word is taken at a time (s_tready is
// high only while the sequencer is idle). for a sampler word with a timestamp
// the wrapped time step is added, the whole-second threshold (drawn seconds +
// 1) * ticks_per_second is formed on a 17 x 30 multiplier in two passes, the
// bin BINS * elapsed / previous width comes out of a restoring divider one
// quotient bit a cycle (the first hit of a spill goes to bin 0, one past the
// previous width to the last bin), and the bin memory is read and written
// back. a skip word or unused kind touches no bin. a spill start forms
// elapsed / 10, sixteen bits a cycle from a reciprocal multiply, and adds it
// to elapsed for the new previous width (elapsed * 11 / 10). a readout sends
// BINS words at one word a cycle, slower only when m_tready holds it off; the
// last bin word is held in the output register while the next input word is
// already taken. histogram entries carry valid bits cleared at reset and spill
// start, so there is no clearing pass. enable low drops every word.
module spill_profile_histogrammer import sph_pkg::*; #(
	parameter int BINS = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                    s_tvalid,
	output      logic                    s_tready,
	input  wire logic [WORD_W-1:0]       s_tdata,  // sample_word
	input  wire logic [MODE_W-1:0]       s_tuser,  // mode
	input  wire logic                    s_tlast,  // last_in_event
	output      logic                    m_tvalid,
	input  wire logic                    m_tready,
	output      logic [OUT_TDATA_W-1:0]  m_tdata,  // bin_index, bin_count, max_count, spill_ticks, zero pad
	output      logic                    m_tlast   // last
);

	localparam int ADDR_W = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int NUM_W  = TICK_W + ADDR_W;
	localparam int PROD_W = CNT_W + 1 + TS_W;
	localparam logic [ADDR_W-1:0] LAST_BIN = ADDR_W'(BINS - 1);

	// divide by ten, one 16-bit digit a cycle; ceil(2^23 / 10) is exact for
	// every partial dividend below 10 * 2^16
	localparam int TEN_DIG_W = 16;
	localparam int TEN_V_W   = TEN_DIG_W + 4;
	localparam int TEN_P_W   = 2 * TEN_V_W;
	localparam int TEN_SH    = 23;
	localparam logic [TEN_V_W-1:0] TEN_RECIP = 20'd838861;
	localparam logic [TEN_V_W-1:0] TEN_DIV   = 20'd10;

	// configuration
	logic              enable_q;
	logic [TS_W-1:0]   tps_q;

	// sequencer and per-word context
	state_t            state_q;
	logic [TS_W-1:0]   ts_q;
	logic              last_ev_q;

	// profile state
	logic [TS_W-1:0]   prev_ts_q;
	logic              have_prev_q;
	logic [TICK_W-1:0] elapsed_q;
	logic [TICK_W-1:0] width_q;
	logic [CNT_W-1:0]  drawn_q;
	logic              pending_q;
	logic [CNT_W-1:0]  max_q;
	logic [BINS-1:0]   vld_q;

	// arithmetic units
	logic [45:0]       pp_q;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0]  rem_q;
	logic [5:0]        cnt_q;
	logic [TICK_W-1:0] dvd_q;
	logic [3:0]        r10_q;
	logic [ADDR_W-1:0] bin_q;

	// bin memory
	logic [CNT_W-1:0]  hist_mem [BINS];
	logic [CNT_W-1:0]  mem_rd_q;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_ra;
	logic              mem_we;
	logic [CNT_W-1:0]  mem_wd;

	// readout pipeline
	logic [ADDR_W-1:0] rd_addr_q;
	logic              rd_left_q;
	logic              rd_pend_q;
	logic [ADDR_W-1:0] rd_bin_s1;
	logic              rd_vld_s1;

	// output register
	logic              ob_valid_q;
	logic [ADDR_W-1:0] ob_bin_q;
	logic [CNT_W-1:0]  ob_cnt_q;
	logic [CNT_W-1:0]  ob_max_q;
	logic [TICK_W-1:0] ob_ticks_q;
	logic              ob_last_q;

	// combinational helpers
	logic               in_acc;
	logic [TS_W-1:0]    dt;
	logic [TICK_W:0]    add_sum;
	logic [CNT_W:0]     sec_next;
	logic [NUM_W-1:0]   div_sh;
	logic               div_ge;
	logic [TEN_V_W-1:0] ten_v;
	logic [TEN_P_W-1:0] ten_p;
	logic [TEN_DIG_W-1:0] ten_qd;
	logic [TEN_V_W-1:0] ten_rq;
	logic [TICK_W:0]    wid_sum;
	logic [CNT_W-1:0]   cur_cnt;
	logic [CNT_W-1:0]   new_cnt;
	logic               out_free;
	logic               rd_load;
	logic               rd_issue;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// wrapped time step, 30-bit subtraction wraps by itself
	assign dt       = ts_q - prev_ts_q;
	assign add_sum  = {1'b0, elapsed_q} + {{(TICK_W - TS_W + 1){1'b0}}, dt};
	assign sec_next = {1'b0, drawn_q} + {{CNT_W{1'b0}}, 1'b1};

	// restoring divide step: divisor shifted to the current quotient bit
	assign div_sh = NUM_W'(width_q) << cnt_q;
	assign div_ge = (rem_q >= div_sh);

	// divide by ten: remainder so far and the next 16-bit digit
	assign ten_v  = {r10_q, dvd_q[TICK_W-1 -: TEN_DIG_W]};
	assign ten_p  = TEN_P_W'(ten_v) * TEN_P_W'(TEN_RECIP);
	assign ten_qd = ten_p[TEN_SH +: TEN_DIG_W];
	assign ten_rq = ten_v - TEN_V_W'(ten_qd) * TEN_DIV;

	// elapsed + elapsed / 10 = floor(elapsed * 11 / 10)
	assign wid_sum = {1'b0, elapsed_q} + {1'b0, dvd_q};

	assign cur_cnt = vld_q[bin_q] ? mem_rd_q : '0;
	assign new_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + CNT_W'(1);

	// readout: one memory read in flight feeds the output register
	assign out_free = !ob_valid_q || m_tready;
	assign rd_load  = (state_q == ST_DRAW) && rd_pend_q && out_free;
	assign rd_issue = (state_q == ST_DRAW) && rd_left_q && (!rd_pend_q || rd_load);

	always_comb begin
		mem_re = 1'b0;
		mem_ra = bin_q;
		mem_we = 1'b0;
		mem_wd = new_cnt;
		if (state_q == ST_RD) begin
			mem_re = 1'b1;
		end
		if (rd_issue) begin
			mem_re = 1'b1;
			mem_ra = rd_addr_q;
		end
		if (state_q == ST_WR) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[bin_q] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= hist_mem[mem_ra];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			tps_q    <= TPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_TPS:    tps_q    <= cfg_data;
				default:    ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ts_q        <= '0;
			last_ev_q   <= 1'b0;
			prev_ts_q   <= '0;
			have_prev_q <= 1'b1;
			elapsed_q   <= TICK_RESET;
			width_q     <= TICK_RESET;
			drawn_q     <= '0;
			pending_q   <= 1'b0;
			max_q       <= '0;
			vld_q       <= '0;
			pp_q        <= '0;
			prod_q      <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			dvd_q       <= '0;
			r10_q       <= '0;
			bin_q       <= '0;
			rd_addr_q   <= '0;
			rd_left_q   <= 1'b0;
			rd_pend_q   <= 1'b0;
			rd_bin_s1   <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && enable_q) begin
						unique case (s_tuser)
							MODE_SAMPLE: begin
								ts_q      <= s_tdata[TS_W-1:0];
								last_ev_q <= s_tlast;
								if ((s_tdata & SKIP_BIT) == '0) begin
									state_q <= ST_ADD;
								end else if (s_tlast && pending_q) begin
									// end of event with a whole second pending
									state_q   <= ST_DRAW;
									pending_q <= 1'b0;
									rd_addr_q <= '0;
									rd_left_q <= 1'b1;
									rd_pend_q <= 1'b0;
								end
							end
							MODE_SPILL: begin
								vld_q       <= '0;
								max_q       <= '0;
								have_prev_q <= 1'b0;
								drawn_q     <= '0;
								dvd_q       <= elapsed_q;
								r10_q       <= '0;
								cnt_q       <= 6'(TICK_W / TEN_DIG_W - 1);
								state_q     <= ST_TEN;
							end
							MODE_DRAW: begin
								state_q   <= ST_DRAW;
								pending_q <= 1'b0;
								rd_addr_q <= '0;
								rd_left_q <= 1'b1;
								rd_pend_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_ADD: begin
					if (have_prev_q) begin
						elapsed_q <= add_sum[TICK_W] ? '1 : add_sum[TICK_W-1:0];
						state_q   <= ST_MUL0;
					end else begin
						// first hit after a spill start
						bin_q   <= '0;
						state_q <= ST_RD;
					end
				end
				ST_MUL0: begin
					pp_q    <= 46'(sec_next[15:0]) * 46'(tps_q);
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					prod_q  <= PROD_W'(pp_q) +
						((PROD_W'(sec_next[CNT_W:16]) * PROD_W'(tps_q)) << 16);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (drawn_q != '1 && prod_q < PROD_W'(elapsed_q)) begin
						drawn_q   <= sec_next[CNT_W-1:0];
						pending_q <= 1'b1;
					end
					// past the previous width, or zero width: last bin
					if (elapsed_q >= width_q) begin
						bin_q   <= LAST_BIN;
						state_q <= ST_RD;
					end else begin
						rem_q   <= NUM_W'(elapsed_q) * NUM_W'(BINS);
						cnt_q   <= 6'(ADDR_W - 1);
						bin_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_ge) begin
						rem_q <= rem_q - div_sh;
					end
					bin_q <= ADDR_W'({bin_q, div_ge});
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					vld_q[bin_q] <= 1'b1;
					if (new_cnt > max_q) begin
						max_q <= new_cnt;
					end
					prev_ts_q   <= ts_q;
					have_prev_q <= 1'b1;
					if (last_ev_q && pending_q) begin
						state_q   <= ST_DRAW;
						pending_q <= 1'b0;
						rd_addr_q <= '0;
						rd_left_q <= 1'b1;
						rd_pend_q <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_TEN: begin
					// next quotient digit shifts in, remainder carries on
					r10_q <= ten_rq[3:0];
					dvd_q <= {dvd_q[TICK_W-TEN_DIG_W-1:0], ten_qd};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= ST_WID;
					end
				end
				ST_WID: begin
					width_q   <= wid_sum[TICK_W] ? '1 : wid_sum[TICK_W-1:0];
					elapsed_q <= '0;
					state_q   <= ST_IDLE;
				end
				ST_DRAW: begin
					if (rd_issue) begin
						rd_vld_s1 <= vld_q[rd_addr_q];
						rd_bin_s1 <= rd_addr_q;
						rd_pend_q <= 1'b1;
						rd_addr_q <= rd_addr_q + ADDR_W'(1);
						if (rd_addr_q == LAST_BIN) begin
							rd_left_q <= 1'b0;
						end
					end else if (rd_load) begin
						rd_pend_q <= 1'b0;
					end
					if (rd_load && rd_bin_s1 == LAST_BIN) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_valid_q <= 1'b0;
			ob_bin_q   <= '0;
			ob_cnt_q   <= '0;
			ob_max_q   <= '0;
			ob_ticks_q <= '0;
			ob_last_q  <= 1'b0;
		end else if (rd_load) begin
			ob_valid_q <= 1'b1;
			ob_bin_q   <= rd_bin_s1;
			ob_cnt_q   <= rd_vld_s1 ? mem_rd_q : '0;
			ob_max_q   <= max_q;
			ob_ticks_q <= elapsed_q;
			ob_last_q  <= (rd_bin_s1 == LAST_BIN);
		end else if (m_tready) begin
			ob_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = ob_valid_q;
	assign m_tlast  = ob_last_q;
	assign m_tdata  = OUT_TDATA_W'({ob_ticks_q, ob_max_q, ob_cnt_q, BIDX_W'(ob_bin_q)});

endmodule

`default_nettype wire

### src/sph_checker.sv
// checker: port-level properties of the histogrammer, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module sph_checker import sph_pkg::*; #(
	parameter int BINS = 64
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic                   m_tlast
);

	// a stalled word stays offered
	`SPH_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// readout ends on the top bin
	`SPH_ASSERT_IMP(a_last_bin, clk, arst_n, m_tvalid && m_tlast, m_tdata[BIDX_W-1:0] == BIDX_W'(BINS - 1))

	// bins follow one another without gaps
	`SPH_ASSERT_NXT(a_next_bin, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[BIDX_W-1:0] == $past(m_tdata[BIDX_W-1:0]) + 6'd1))

	// no input word is taken in the middle of a readout
	`SPH_ASSERT_IMP(a_busy_draw, clk, arst_n, m_tvalid && !m_tlast, !s_tready)

endmodule

bind spill_profile_histogrammer sph_checker #(.BINS(BINS)) u_sph_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

### sim/spill_profile_histogrammer_tb.sv
// testbench: spill profile histogrammer checked word by word against its own bin-profile predictor
`timescale 1ns / 100ps

module spill_profile_histogrammer_tb;
	import sph_pkg::*;

	localparam int BINS       = 64;
	localparam int SETTLE     = 80;    // settling wait so a sampler word taken last can run to its end
	localparam int IDLE_LIMIT = 2000;  // cycles without any accepted word before giving up
	localparam int NPH        = 7;

	localparam logic [MODE_W-1:0]     MODE_SPARE = 2'd3;
	localparam logic [CFG_DATA_W-1:0] TPS_TOP    = 30'd1000000000;
	localparam logic [TICK_W-1:0]     TICK_SAT   = '1;

	// one input word, plus a typed readout where the table gives one
	typedef struct packed {
		logic [MODE_W-1:0] kind;
		logic [WORD_W-1:0] word;
		logic              eoe;
		logic              typed;
		logic [TICK_W-1:0] t_ticks;
		logic [CNT_W-1:0]  t_peak;
		logic [BIDX_W-1:0] t_bin;
		logic [CNT_W-1:0]  t_cnt;
	} stim_t;

	// one bin word of a readout
	typedef struct packed {
		logic [BIDX_W-1:0] idx;
		logic [CNT_W-1:0]  cnt;
		logic [CNT_W-1:0]  peak;
		logic [TICK_W-1:0] ticks;
		logic              fin;
	} bin_word_t;

	// one setting of the registers and the words sent under it
	typedef struct packed {
		logic                  en;
		logic                  rnd;
		logic [CFG_DATA_W-1:0] tps;
		logic [15:0]           items;
	} phase_t;

	// directed words: extremes, every kind, wrap, zero width, typed readouts
	localparam stim_t DIR_ROWS [18] = '{
		// readout straight after reset: empty bins, reset spill time
		'{MODE_DRAW,   32'h0000_0000, 1'b0, 1'b1, TICK_RESET, 32'd0, 6'd0, 32'd0},
		// largest timestamp against the reset one, lands in the last bin
		'{MODE_SAMPLE, 32'h3FFF_FFFF, 1'b0, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		// skip word closing the event, whole second pending
		'{MODE_SAMPLE, 32'hFFFF_FFFF, 1'b1, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		// spare kind is dropped
		'{MODE_SPARE,  32'h5555_AAAA, 1'b1, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		'{MODE_SPILL,  32'hFFFF_FFFF, 1'b1, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		// fresh spill: everything cleared
		'{MODE_DRAW,   32'hFFFF_FFFF, 1'b1, 1'b1, 48'd0, 32'd0, 6'd0, 32'd0},
		// first word of the spill goes to bin 0 and adds nothing
		'{MODE_SAMPLE, 32'h0000_0000, 1'b0, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		'{MODE_DRAW,   32'h0000_0000, 1'b0, 1'b1, 48'd0, 32'd1, 6'd0, 32'd1},
		// bit 30 is not part of the timestamp
		'{MODE_SAMPLE, 32'h4000_0010, 1'b0, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		'{MODE_SAMPLE, 32'h3FFF_FFFF, 1'b1, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		// two spill starts back to back leave a zero previous width
		'{MODE_SPILL,  32'h0000_0000, 1'b0, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		'{MODE_SPILL,  32'h0000_0000, 1'b0, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		'{MODE_SAMPLE, 32'h0000_0005, 1'b0, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		// timestamp steps backwards: wraps to a near full step, last bin
		'{MODE_SAMPLE, 32'h0000_0004, 1'b1, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		'{MODE_DRAW,   32'hA5A5_5A5A, 1'b0, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		'{MODE_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		// skip word without event end: nothing happens
		'{MODE_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0},
		'{MODE_DRAW,   32'h0000_0000, 1'b1, 1'b0, 48'd0, 32'd0, 6'd0, 32'd0}
	};

	// register settings walked by the random part; zero, one and TPS_TOP are the rate extremes
	localparam phase_t PHASES [NPH] = '{
		'{1'b1, 1'b0, 30'd0,     16'd40},
		'{1'b1, 1'b0, 30'd1,     16'd50},
		'{1'b1, 1'b0, TPS_TOP,   16'd55},
		'{1'b0, 1'b1, 30'd0,     16'd15},
		'{1'b1, 1'b0, TPS_RESET, 16'd55},
		'{1'b1, 1'b1, 30'd0,     16'd60},
		'{1'b1, 1'b1, 30'd0,     16'd50}
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_ADDR_W-1:0]  cfg_addr;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [WORD_W-1:0]      s_tdata;   // sample_word
	logic [MODE_W-1:0]      s_tuser;   // mode
	logic                   s_tlast;   // last_in_event
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;   // bin_index, bin_count, max_count, spill_ticks, zero pad
	logic                   m_tlast;   // last

	// predictor copy of the block state and registers
	logic                  prof_on;
	logic [CFG_DATA_W-1:0] tick_rate;
	logic [CNT_W-1:0]      hist_cnt [BINS];
	logic [TS_W-1:0]       last_stamp;
	logic                  stamp_valid;
	logic [TICK_W-1:0]     spill_time;
	logic [TICK_W-1:0]     width_ref;
	logic [31:0]           secs_drawn;
	logic                  draw_due;
	logic [CNT_W-1:0]      peak_cnt;

	bin_word_t bins_due[$];
	int        fails = 0;
	int        burst_left = 1;
	int        stall_left = 0;
	int        quiet_cycles = 0;
	logic [15:0] rx_cyc = '0;
	logic [TS_W-1:0] gen_stamp = '0;
	int        gen_pace = 1 << 20;

	spill_profile_histogrammer #(.BINS(BINS)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// advances the predicted state by one accepted word; high when a readout follows
	function automatic bit profile_step(input stim_t s);
		logic [TS_W-1:0]   stamp;
		logic [TS_W-1:0]   step;
		logic [TICK_W:0]   sum;
		logic [63:0]       thresh;
		logic [63:0]       quo;
		logic [63:0]       wide;
		int                bin;
		if (!prof_on)
			return 1'b0;
		case (s.kind)
			MODE_SAMPLE: begin
				if ((s.word & SKIP_BIT) == '0) begin
					stamp = s.word[TS_W-1:0];
					bin = 0;
					if (stamp_valid) begin
						// time step taken modulo the timestamp range
						step = stamp - last_stamp;
						sum = {1'b0, spill_time} + (TICK_W + 1)'(step);
						spill_time = sum[TICK_W] ? TICK_SAT : sum[TICK_W-1:0];
						thresh = (64'(secs_drawn) + 64'd1) * 64'(tick_rate);
						if (secs_drawn != '1 && thresh < 64'(spill_time)) begin
							secs_drawn++;
							draw_due = 1'b1;
						end
						if (width_ref == '0) begin
							bin = BINS - 1;
						end else begin
							quo = (64'(BINS) * 64'(spill_time)) / 64'(width_ref);
							bin = (quo >= 64'(BINS)) ? BINS - 1 : int'(quo);
						end
					end
					if (hist_cnt[bin] != '1)
						hist_cnt[bin]++;
					if (hist_cnt[bin] > peak_cnt)
						peak_cnt = hist_cnt[bin];
					last_stamp = stamp;
					stamp_valid = 1'b1;
				end
				if (s.eoe && draw_due) begin
					draw_due = 1'b0;
					return 1'b1;
				end
				return 1'b0;
			end
			MODE_SPILL: begin
				for (int i = 0; i < BINS; i++)
					hist_cnt[i] = '0;
				peak_cnt = '0;
				stamp_valid = 1'b0;
				secs_drawn = '0;
				wide = (64'(spill_time) * 64'd11) / 64'd10;
				width_ref = (wide > 64'(TICK_SAT)) ? TICK_SAT : wide[TICK_W-1:0];
				spill_time = '0;
				return 1'b0;
			end
			MODE_DRAW: begin
				draw_due = 1'b0;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// queues the BINS words of one readout, typed from the table or from the state
	function automatic void queue_readout(input stim_t s);
		bin_word_t w;
		for (int i = 0; i < BINS; i++) begin
			w.idx = BIDX_W'(i);
			w.fin = (i == BINS - 1);
			if (s.typed) begin
				w.cnt   = (BIDX_W'(i) == s.t_bin) ? s.t_cnt : '0;
				w.peak  = s.t_peak;
				w.ticks = s.t_ticks;
			end else begin
				w.cnt   = hist_cnt[i];
				w.peak  = peak_cnt;
				w.ticks = spill_time;
			end
			bins_due.push_back(w);
		end
	endfunction

	// random word of a spill run; open forces a spill start with a new pace
	function automatic stim_t spill_row(input bit open);
		stim_t s;
		int    pick;
		s = '0;
		pick = open ? 99 : $urandom_range(0, 99);
		s.word = $urandom;
		s.eoe = ($urandom_range(0, 3) == 0);
		if (pick < 68) begin
			// well-formed sampler word, steady pace with jitter
			gen_stamp = gen_stamp + TS_W'($urandom_range(gen_pace / 2, gen_pace + gen_pace / 2));
			s.kind = MODE_SAMPLE;
			s.word = {1'b0, 1'($urandom), gen_stamp};
		end else if (pick < 78) begin
			s.kind = MODE_SAMPLE;
			s.word = s.word | SKIP_BIT;
		end else if (pick < 85) begin
			s.kind = MODE_DRAW;
		end else if (pick < 89) begin
			s.kind = MODE_SPARE;
		end else if (pick < 94) begin
			// stray timestamp out of sequence
			s.kind = MODE_SAMPLE;
			s.word = s.word & ~SKIP_BIT;
		end else begin
			s.kind = MODE_SPILL;
			gen_pace = $urandom_range(1, 1 << 27);
		end
		return s;
	endfunction

	task automatic note_fault(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		fails++;
	endtask

	// config write, waiting once more after cfg_we drops so the enable never toggles within one step
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ENABLE)
			prof_on = val[0];
		else
			tick_rate = val;
		@(posedge clk);
	endtask

	// offers one word, predicts on acceptance, then maybe ends the burst with a gap
	task automatic push_word(input stim_t s);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= s.kind;
		s_tdata  <= s.word;
		s_tlast  <= s.eoe;
		do @(posedge clk); while (!s_tready);
		if (profile_step(s) || s.typed)
			queue_readout(s);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// sender holds off until every bin word has come and the block has gone quiet
	task automatic settle_out();
		s_tvalid <= 1'b0;
		while (bins_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// receiver: random stalls, with calm stretches in between while bit 9 of rx_cyc is set
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 16'd1;
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!rx_cyc[9] && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 19);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// bin word checker: oldest expectation first, every field on its own
	always @(posedge clk) begin
		bin_word_t got;
		bin_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.idx   = m_tdata[0 +: BIDX_W];
			got.cnt   = m_tdata[BIDX_W +: CNT_W];
			got.peak  = m_tdata[BIDX_W + CNT_W +: CNT_W];
			got.ticks = m_tdata[BIDX_W + 2 * CNT_W +: TICK_W];
			got.fin   = m_tlast;
			if (bins_due.size() == 0) begin
				note_fault($sformatf("bin word %0d with nothing due", got.idx));
			end else begin
				want = bins_due.pop_front();
				if (got.idx != want.idx)
					note_fault($sformatf("bin_index %0d, want %0d", got.idx, want.idx));
				if (got.cnt != want.cnt)
					note_fault($sformatf("bin %0d count %0d, want %0d",
						want.idx, got.cnt, want.cnt));
				if (got.peak != want.peak)
					note_fault($sformatf("bin %0d max_count %0d, want %0d",
						want.idx, got.peak, want.peak));
				if (got.ticks != want.ticks)
					note_fault($sformatf("bin %0d spill_ticks %0d, want %0d",
						want.idx, got.ticks, want.ticks));
				if (got.fin != want.fin)
					note_fault($sformatf("bin %0d last %0b, want %0b",
						want.idx, got.fin, want.fin));
			end
		end
	end

	// watchdog: any accepted word or register write resets the count
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_addr <= REG_ENABLE;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= MODE_SAMPLE;
		s_tlast  <= 1'b0;

		// predictor starts from the reset state
		prof_on = 1'b0;
		tick_rate = TPS_RESET;
		for (int i = 0; i < BINS; i++)
			hist_cnt[i] = '0;
		last_stamp = '0;
		stamp_valid = 1'b1;
		spill_time = TICK_RESET;
		width_ref = TICK_RESET;
		secs_drawn = '0;
		draw_due = 1'b0;
		peak_cnt = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// profiling off: every word dropped, nothing may come out
		write_reg(REG_ENABLE, CFG_DATA_W'(0));
		repeat (12) push_word(spill_row(1'b0));
		settle_out();
		write_reg(REG_ENABLE, CFG_DATA_W'(1));

		foreach (DIR_ROWS[i])
			push_word(DIR_ROWS[i]);

		// random spill runs, each setting opened by a spill start
		for (int ph = 0; ph < NPH; ph++) begin
			settle_out();
			write_reg(REG_ENABLE, CFG_DATA_W'(PHASES[ph].en));
			write_reg(REG_TPS, PHASES[ph].rnd ?
				CFG_DATA_W'($urandom_range(1, 1000000000)) : PHASES[ph].tps);
			push_word(spill_row(1'b1));
			repeat (int'(PHASES[ph].items) - 1) push_word(spill_row(1'b0));
		end
		settle_out();

		if (fails == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
